// ===== sv/utf8s_pkg.sv =====
`timescale 1ns / 1ps

package utf8s_pkg;

    localparam int CP_W = 21;

    localparam logic [CP_W-1:0] CP_SURR_LO  = 21'h00D800;
    localparam logic [CP_W-1:0] CP_SURR_HI  = 21'h00DFFF;
    localparam logic [CP_W-1:0] CP_NCHAR_LO = 21'h00FDD0;
    localparam logic [CP_W-1:0] CP_NCHAR_HI = 21'h00FDEF;
    localparam logic [CP_W-1:0] CP_BOM      = 21'h00FEFF;
    localparam logic [CP_W-1:0] CP_EMB_LO   = 21'h00202A;
    localparam logic [CP_W-1:0] CP_EMB_HI   = 21'h00202E;
    localparam logic [CP_W-1:0] CP_ISO_LO   = 21'h002066;
    localparam logic [CP_W-1:0] CP_ISO_HI   = 21'h002069;
    localparam logic [CP_W-1:0] CP_ZW_LO    = 21'h00200B;
    localparam logic [CP_W-1:0] CP_ZW_HI    = 21'h00200D;
    localparam logic [CP_W-1:0] CP_LIM_1    = 21'h000080;
    localparam logic [CP_W-1:0] CP_LIM_2    = 21'h000800;
    localparam logic [CP_W-1:0] CP_LIM_3    = 21'h010000;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_string;
    } t_in;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_of_run;
    } t_out;

    typedef struct packed {
        logic [2:0]  len;
        logic [31:0] data;
    } t_run;

    typedef struct packed {
        logic load;
        t_run run;
    } t_cmd;

    function automatic logic cp_dangerous(input logic [CP_W-1:0] cp);
        logic d;
        d = (cp == '0)
            || (cp >= CP_SURR_LO && cp <= CP_SURR_HI)
            || (cp >= CP_NCHAR_LO && cp <= CP_NCHAR_HI)
            || (cp[15:1] == '1)
            || (cp == CP_BOM)
            || (cp >= CP_EMB_LO && cp <= CP_EMB_HI)
            || (cp >= CP_ISO_LO && cp <= CP_ISO_HI)
            || (cp >= CP_ZW_LO && cp <= CP_ZW_HI);
        return d;
    endfunction

    function automatic t_run cp_encode(input logic [CP_W-1:0] cp);
        t_run r;
        if (cp < CP_LIM_1) begin
            r.len  = 3'd1;
            r.data = {cp[7:0], 24'h0};
        end else if (cp < CP_LIM_2) begin
            r.len  = 3'd2;
            r.data = {3'b110, cp[10:6], 2'b10, cp[5:0], 16'h0};
        end else if (cp < CP_LIM_3) begin
            r.len  = 3'd3;
            r.data = {4'b1110, cp[15:12], 2'b10, cp[11:6], 2'b10, cp[5:0], 8'h0};
        end else begin
            r.len  = 3'd4;
            r.data = {5'b11110, cp[20:18], 2'b10, cp[17:12], 2'b10, cp[11:6],
                      2'b10, cp[5:0]};
        end
        return r;
    endfunction

endpackage

// ===== sv/utf8s_decode.sv =====
`timescale 1ns / 1ps

module utf8s_decode
    import utf8s_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_take,
    input  t_in  i_data,
    output t_cmd o_cmd
);

    logic [CP_W-1:0] r_partial, n_partial;
    logic [1:0]      r_expect, n_expect;
    logic [CP_W-1:0] cp;
    logic            emit;
    logic [7:0]      b;

    assign b = i_data.in_byte;

    always_comb begin
        n_partial = r_partial;
        n_expect  = r_expect;
        cp        = '0;
        emit      = 1'b0;
        if (r_expect != 2'd0 && b[7:6] == 2'b10) begin
            n_partial = {r_partial[CP_W-7:0], b[5:0]};
            n_expect  = r_expect - 2'd1;
            if (n_expect == 2'd0) begin
                cp        = n_partial;
                emit      = 1'b1;
                n_partial = '0;
            end
        end else begin
            n_partial = '0;
            n_expect  = 2'd0;
            priority if (b[7] == 1'b0) begin
                cp   = {{(CP_W-8){1'b0}}, b};
                emit = 1'b1;
            end else if (b[7:5] == 3'b110) begin
                n_partial = {{(CP_W-5){1'b0}}, b[4:0]};
                n_expect  = 2'd1;
            end else if (b[7:4] == 4'b1110) begin
                n_partial = {{(CP_W-4){1'b0}}, b[3:0]};
                n_expect  = 2'd2;
            end else if (b[7:3] == 5'b11110) begin
                n_partial = {{(CP_W-3){1'b0}}, b[2:0]};
                n_expect  = 2'd3;
            end else begin
                n_partial = '0;
            end
        end
        if (i_data.end_of_string) begin
            n_partial = '0;
            n_expect  = 2'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_partial <= '0;
            r_expect  <= 2'd0;
        end else if (i_take) begin
            r_partial <= n_partial;
            r_expect  <= n_expect;
        end
    end

    assign o_cmd.load = i_take && emit && !cp_dangerous(cp);
    assign o_cmd.run  = cp_encode(cp);

endmodule

// ===== sv/utf8s_serialize.sv =====
`timescale 1ns / 1ps

module utf8s_serialize
    import utf8s_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_cmd i_cmd,
    output logic o_free,
    output logic o_valid,
    input  logic i_stall,
    output t_out o_data
);

    logic [2:0]  r_left;
    logic [31:0] r_data;
    logic        r_held;
    t_run        r_hold;
    logic        shift;
    logic        done;

    assign done   = (r_left == 3'd0) || (r_left == 3'd1 && !i_stall);
    assign shift  = (r_left != 3'd0) && !i_stall;
    assign o_free = !r_held || done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left <= 3'd0;
            r_held <= 1'b0;
        end else begin
            if (done && r_held) begin
                r_left <= r_hold.len;
            end else if (done && i_cmd.load) begin
                r_left <= i_cmd.run.len;
            end else if (shift) begin
                r_left <= r_left - 3'd1;
            end
            if (done) begin
                r_held <= r_held && i_cmd.load;
            end else if (i_cmd.load) begin
                r_held <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (done && r_held) begin
            r_data <= r_hold.data;
        end else if (done && i_cmd.load) begin
            r_data <= i_cmd.run.data;
        end else if (shift) begin
            r_data <= {r_data[23:0], 8'h00};
        end
        if (i_cmd.load && (r_held || !done)) begin
            r_hold <= i_cmd.run;
        end
    end

    assign o_valid            = (r_left != 3'd0);
    assign o_data.out_byte    = r_data[31:24];
    assign o_data.last_of_run = (r_left == 3'd1);

endmodule

// ===== sv/utf8_sanitizer.sv =====
// Streaming UTF-8 filter: each input item is one raw byte, decoded against the pending
// sequence and, when a code point completes and is not dangerous, re-encoded in shortest
// form as one to four output items, the final one flagged last_of_run. A completed run is
// sent from the output byte register, one byte per unstalled cycle; a run that completes
// while that register is still sending waits in a one-run holding register. An input item
// is taken in every cycle unless the holding register is occupied and the output
// register is not handing over its final byte, so back-to-back input stalls only behind a
// backlog of two runs or a stalled receiver; the output byte rate sets the sustained rate.
`timescale 1ns / 1ps

module utf8_sanitizer
    import utf8s_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_stall,
    input  t_in  i_data,
    output logic o_valid,
    input  logic i_stall,
    output t_out o_data
);

    t_cmd cmd;
    logic free;
    logic take;

    assign o_stall = !free;
    assign take    = i_valid && free;

    utf8s_decode u_decode (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_take  (take),
        .i_data  (i_data),
        .o_cmd   (cmd)
    );

    utf8s_serialize u_serialize (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .o_free  (free),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_data  (o_data)
    );

endmodule

// ===== sv/utf8s_checker.sv =====
`timescale 1ns / 1ps

module utf8s_checker
    import utf8s_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic i_valid,
    input logic o_stall,
    input t_in  i_data,
    input logic o_valid,
    input logic i_stall,
    input t_out o_data
);

    a_reset_clears: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

    a_stall_needs_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid)
        else $error("input stalled with no pending output");

    a_run_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_stall && !o_data.last_of_run)
        |=> (o_valid && o_data.out_byte[7:6] == 2'b10))
        else $error("run broken before its last byte");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_data)))
        else $error("stalled output item changed");

    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_stall) |=> (i_valid && $stable(i_data)))
        else $error("stalled input item changed");

endmodule

bind utf8_sanitizer utf8s_checker u_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (i_valid),
    .o_stall (o_stall),
    .i_data  (i_data),
    .o_valid (o_valid),
    .i_stall (i_stall),
    .o_data  (o_data)
);
